FILE: hdl/psin_pkg.sv
`timescale 1ns / 1ps
package psin_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 20;
  localparam int SUM_W      = 26;
  localparam int CEN_W      = 26;
  localparam int DIFF_W     = 25;
  localparam int SQ_W       = 50;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int DIV_W      = 40;
  localparam int DSUM_W     = 40;
  localparam int SCALE_W    = 32;
  localparam int OFF_W      = 40;
  localparam int NORM_W     = 24;

  localparam logic [DIV_W-1:0] SQRT2_Q32 = 40'd6074000999;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic [SCALE_W-1:0]       scale;
    logic signed [OFF_W-1:0]  offset_x;
    logic signed [OFF_W-1:0]  offset_y;
    logic                     degenerate;
    logic                     final_res;
  } out_item_t;

endpackage

FILE: hdl/psin_ram.sv
`timescale 1ns / 1ps
module psin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/psin_div.sv
`timescale 1ns / 1ps
module psin_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [psin_pkg::DIV_W-1:0] dividend,
  input  logic [psin_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [psin_pkg::DIV_W-1:0] quotient
);
  import psin_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r && !start |=> !done_r || !busy_r)
    else $error("divider done flag inconsistent");

endmodule

FILE: hdl/psin_sqrt.sv
`timescale 1ns / 1ps
module psin_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psin_pkg::SQ_W-1:0]   radicand,
  output logic                        done,
  output logic [psin_pkg::ROOT_W-1:0] root
);
  import psin_pkg::*;

  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   v_r, v_nxt;
  logic [SQ_W-1:0]   r_r, r_nxt;
  logic [SQ_W-1:0]   b_r, b_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SQ_W-1:0]   trial;

  always_comb begin
    trial    = r_r + b_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = radicand;
      r_nxt    = '0;
      b_nxt    = SQ_W'(1) << (SQ_W - 2);
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt    = b_r >> 2;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    v_r <= v_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> $onehot(b_r))
    else $error("square root bit lost");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("square root done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("square root did not start");

endmodule

FILE: hdl/point_set_isotropic_normalizer_unit.sv
`timescale 1ns / 1ps
// Loading accepts one item per cycle; items are refused while a set is processed.
// After the item marked last, the set is processed with four divisions (three for a degenerate
// set) on the shared bit-per-cycle divider and, per point, a pass through the 25-step square
// root; each result is then held until it is accepted. Reset (synchronous, active low) empties
// the set and drops results.
module point_set_isotropic_normalizer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psin_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psin_pkg::out_item_t out_data
);
  import psin_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_DIVX = 4'd1;
  localparam logic [3:0] S_DIVY = 4'd2;
  localparam logic [3:0] S_DRD  = 4'd3;
  localparam logic [3:0] S_DDX  = 4'd4;
  localparam logic [3:0] S_DSQ  = 4'd5;
  localparam logic [3:0] S_DRT  = 4'd6;
  localparam logic [3:0] S_DSW  = 4'd7;
  localparam logic [3:0] S_MD   = 4'd8;
  localparam logic [3:0] S_SC   = 4'd9;
  localparam logic [3:0] S_OFF1 = 4'd10;
  localparam logic [3:0] S_OFF2 = 4'd11;
  localparam logic [3:0] S_ORD  = 4'd12;
  localparam logic [3:0] S_OMUL = 4'd13;
  localparam logic [3:0] S_ONRM = 4'd14;
  localparam logic [3:0] S_OWT  = 4'd15;

  localparam int PROD_W = SCALE_W + CEN_W + 1;
  localparam int PN_W   = COORD_W + SCALE_W + 1;

  logic [3:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [SUM_W-1:0]  sumx_r, sumx_nxt, sumy_r, sumy_nxt;
  logic signed [CEN_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [DSUM_W-1:0]        dsum_r, dsum_nxt;
  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic                     degen_r, degen_nxt;
  logic signed [PROD_W-1:0] prodx_r, prody_r;
  logic signed [OFF_W-1:0]  offx_r, offy_r;
  logic signed [PN_W-1:0]   pnx_r, pny_r;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     div_go_r, div_go_nxt;
  logic [DIV_W-1:0]         div_a_r, div_a_nxt, div_b_r, div_b_nxt;

  logic                     div_done;
  logic [DIV_W-1:0]         div_q;
  logic                     sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]        sqrt_root;
  logic                     ram_we;
  logic [2*COORD_W-1:0]     ram_q;
  logic signed [COORD_W-1:0] rx, ry;
  logic                     in_acc, out_acc, is_final;

  function automatic logic [DIV_W-1:0] abs16(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W+4:0] w;
    w = (SUM_W + 5)'(s) <<< 4;
    if (w < 0) begin
      w = -w;
    end
    return DIV_W'(unsigned'(w));
  endfunction

  function automatic logic signed [CEN_W-1:0] signq(input logic neg,
                                                    input logic [DIV_W-1:0] q);
    logic signed [CEN_W-1:0] m;
    m = signed'({1'b0, q[CEN_W-2:0]});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [OFF_W-1:0] offcalc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = (PROD_W + 1)'(p);
    if (p < 0) begin
      t = t + 255;
    end
    t = t >>> 8;
    t = -t;
    if (t > ((PROD_W + 1)'(1) <<< (OFF_W - 1)) - 1) begin
      return {1'b0, {(OFF_W-1){1'b1}}};
    end else if (t < -((PROD_W + 1)'(1) <<< (OFF_W - 1))) begin
      return {1'b1, {(OFF_W-1){1'b0}}};
    end
    return t[OFF_W-1:0];
  endfunction

  function automatic logic signed [NORM_W-1:0] normcalc(input logic signed [PN_W-1:0] p,
                                                        input logic signed [OFF_W-1:0] o);
    logic signed [PN_W+1:0] t;
    t = (PN_W + 2)'(p);
    if (p < 0) begin
      t = t + 15;
    end
    t = (t >>> 4) + (PN_W + 2)'(o);
    if (t > ((PN_W + 2)'(1) <<< (NORM_W - 1)) - 1) begin
      return {1'b0, {(NORM_W-1){1'b1}}};
    end else if (t < -((PN_W + 2)'(1) <<< (NORM_W - 1))) begin
      return {1'b1, {(NORM_W-1){1'b0}}};
    end
    return t[NORM_W-1:0];
  endfunction

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ram_we    = in_acc && (cnt_r < CNT_W'(MAX_POINTS));
  assign rx        = signed'(ram_q[2*COORD_W-1:COORD_W]);
  assign ry        = signed'(ram_q[COORD_W-1:0]);
  assign is_final  = (idx_r + 1'b1) == cnt_r;
  assign sqrt_start = (state_r == S_DRT);

  psin_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({in_data.x, in_data.y}),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  psin_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  psin_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqx_r + sqy_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sumx_nxt      = sumx_r;
    sumy_nxt      = sumy_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dsum_nxt      = dsum_r;
    scale_nxt     = scale_r;
    degen_nxt     = degen_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    div_go_nxt    = 1'b0;
    div_a_nxt     = div_a_r;
    div_b_nxt     = div_b_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (ram_we) begin
            sumx_nxt = sumx_r + SUM_W'(in_data.x);
            sumy_nxt = sumy_r + SUM_W'(in_data.y);
            cnt_nxt  = cnt_r + 1'b1;
          end
          if (in_data.last) begin
            div_a_nxt  = abs16(sumx_nxt);
            div_b_nxt  = DIV_W'(cnt_nxt);
            div_go_nxt = 1'b1;
            state_nxt  = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (div_done) begin
          cx_nxt     = signq(sumx_r < 0, div_q);
          div_a_nxt  = abs16(sumy_r);
          div_go_nxt = 1'b1;
          state_nxt  = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          cy_nxt    = signq(sumy_r < 0, div_q);
          idx_nxt   = '0;
          dsum_nxt  = '0;
          state_nxt = S_DRD;
        end
      end
      S_DRD: state_nxt = S_DDX;
      S_DDX: state_nxt = S_DSQ;
      S_DSQ: state_nxt = S_DRT;
      S_DRT: state_nxt = S_DSW;
      S_DSW: begin
        if (sqrt_done) begin
          dsum_nxt = dsum_r + DSUM_W'(sqrt_root);
          if (is_final) begin
            div_a_nxt  = dsum_nxt;
            div_b_nxt  = DIV_W'(cnt_r);
            div_go_nxt = 1'b1;
            state_nxt  = S_MD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      S_MD: begin
        if (div_done) begin
          if (div_q == '0) begin
            degen_nxt = 1'b1;
            scale_nxt = '0;
            state_nxt = S_OFF1;
          end else begin
            degen_nxt  = 1'b0;
            div_a_nxt  = SQRT2_Q32;
            div_b_nxt  = {div_q[DIV_W-9:0], 8'd0};
            div_go_nxt = 1'b1;
            state_nxt  = S_SC;
          end
        end
      end
      S_SC: begin
        if (div_done) begin
          scale_nxt = (div_q > DIV_W'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
                                                         : div_q[SCALE_W-1:0];
          state_nxt = S_OFF1;
        end
      end
      S_OFF1: state_nxt = S_OFF2;
      S_OFF2: begin
        idx_nxt   = '0;
        state_nxt = S_ORD;
      end
      S_ORD:  state_nxt = S_OMUL;
      S_OMUL: state_nxt = S_ONRM;
      S_ONRM: begin
        out_nxt.norm_x     = normcalc(pnx_r, offx_r);
        out_nxt.norm_y     = normcalc(pny_r, offy_r);
        out_nxt.scale      = scale_r;
        out_nxt.offset_x   = offx_r;
        out_nxt.offset_y   = offy_r;
        out_nxt.degenerate = degen_r;
        out_nxt.final_res  = is_final;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_OWT;
      end
      S_OWT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (is_final) begin
            cnt_nxt   = '0;
            sumx_nxt  = '0;
            sumy_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      sumx_r      <= '0;
      sumy_r      <= '0;
      dsum_r      <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      degen_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      sumx_r      <= sumx_nxt;
      sumy_r      <= sumy_nxt;
      dsum_r      <= dsum_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= div_go_nxt;
      degen_r     <= degen_nxt;
    end
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    scale_r <= scale_nxt;
    out_r   <= out_nxt;
    div_a_r <= div_a_nxt;
    div_b_r <= div_b_nxt;
    dx_r    <= DIFF_W'((DIFF_W'(rx) <<< 4) - DIFF_W'(cx_r));
    dy_r    <= DIFF_W'((DIFF_W'(ry) <<< 4) - DIFF_W'(cy_r));
    sqx_r   <= SQ_W'(unsigned'((2 * DIFF_W)'(dx_r) * (2 * DIFF_W)'(dx_r)));
    sqy_r   <= SQ_W'(unsigned'((2 * DIFF_W)'(dy_r) * (2 * DIFF_W)'(dy_r)));
    prodx_r <= PROD_W'(signed'({1'b0, scale_r})) * PROD_W'(cx_r);
    prody_r <= PROD_W'(signed'({1'b0, scale_r})) * PROD_W'(cy_r);
    pnx_r   <= PN_W'(rx) * PN_W'(signed'({1'b0, scale_r}));
    pny_r   <= PN_W'(ry) * PN_W'(signed'({1'b0, scale_r}));
    if (state_r == S_OFF2) begin
      offx_r <= offcalc(prodx_r);
      offy_r <= offcalc(prody_r);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> idx_r < cnt_r)
    else $error("result index beyond point count");
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_acc && in_data.last |=> in_stall)
    else $error("set end did not start processing");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_acc && out_r.final_res |=> cnt_r == '0 && !in_stall)
    else $error("set not cleared after last result");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && out_r.degenerate |-> out_r.scale == '0)
    else $error("degenerate result with nonzero scale");

endmodule

FILE: tb/tb_point_set_isotropic_normalizer_unit.sv
`timescale 1ns / 1ps
module tb_point_set_isotropic_normalizer_unit;
  import psin_pkg::*;

  class normalizer_scoreboard;
    out_item_t expected_q[$];
    longint    pts_x[$];
    longint    pts_y[$];
    int        mismatches;
    int        results_seen;
    int        sets_done;

    function new();
      mismatches   = 0;
      results_seen = 0;
      sets_done    = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint clip(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void note_point(in_item_t it);
      longint          n;
      longint          sx;
      longint          sy;
      longint          cx;
      longint          cy;
      longint          dx;
      longint          dy;
      longint          offx;
      longint          offy;
      longint          sc;
      longint unsigned dsum;
      longint unsigned md;
      out_item_t       r;
      if (pts_x.size() < MAX_POINTS) begin
        pts_x = {pts_x, longint'(it.x)};
        pts_y = {pts_y, longint'(it.y)};
      end
      if (!it.last) return;
      n  = pts_x.size();
      sx = 0;
      sy = 0;
      foreach (pts_x[i]) begin
        sx += pts_x[i];
        sy += pts_y[i];
      end
      cx   = (sx * 16) / n;
      cy   = (sy * 16) / n;
      dsum = 0;
      foreach (pts_x[i]) begin
        dx = pts_x[i] * 16 - cx;
        dy = pts_y[i] * 16 - cy;
        dsum += int_sqrt(longint'(dx * dx) + longint'(dy * dy));
      end
      md   = dsum / n;
      sc   = 0;
      offx = 0;
      offy = 0;
      if (md != 0) begin
        sc = longint'(longint'(SQRT2_Q32) / (md * 256));
        if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
        offx = clip(-((sc * cx) / 256), OFF_W);
        offy = clip(-((sc * cy) / 256), OFF_W);
      end
      foreach (pts_x[i]) begin
        r = '0;
        if (md != 0) begin
          r.norm_x = NORM_W'(clip((pts_x[i] * sc) / 16 + offx, NORM_W));
          r.norm_y = NORM_W'(clip((pts_y[i] * sc) / 16 + offy, NORM_W));
        end
        r.scale      = sc[SCALE_W-1:0];
        r.offset_x   = offx[OFF_W-1:0];
        r.offset_y   = offy[OFF_W-1:0];
        r.degenerate = (md == 0);
        r.final_res  = (i == n - 1);
        expected_q   = {expected_q, r};
      end
      pts_x.delete();
      pts_y.delete();
      sets_done++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d:", results_seen);
          $display("  expected %p", e);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  normalizer_scoreboard sb;
  int idle_in_pct;
  int idle_out_pct;
  int quiet_cycles;
  int items_sent;

  point_set_isotropic_normalizer_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_out_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic last);
    in_item_t it;
    it.x    = x;
    it.y    = y;
    it.last = last;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(it);
    items_sent++;
  endtask

  task automatic send_set(int n, int mode);
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    int                        spread;
    bx     = COORD_W'($urandom);
    by     = COORD_W'($urandom);
    spread = 1 << $urandom_range(12);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin
          px = COORD_W'($urandom);
          py = COORD_W'($urandom);
        end
        1: begin
          px = COORD_W'(bx + $signed($urandom_range(2 * spread)) - spread);
          py = COORD_W'(by + $signed($urandom_range(2 * spread)) - spread);
        end
        default: begin
          px = bx;
          py = by;
        end
      endcase
      send_point(px, py, i == n - 1);
    end
  endtask

  task automatic random_sets(int items);
    int n;
    int target;
    target = items_sent + items;
    while (items_sent < target) begin
      n = $urandom_range(10, 1);
      send_set(n, ($urandom_range(9) < 6) ? 1 : (($urandom_range(3) == 0) ? 2 : 0));
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    idle_in_pct  = 8;
    idle_out_pct = 54;
    quiet_cycles = 0;
    items_sent   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(20'sd1234, -20'sd77, 1'b1);
    send_point(20'sd524287, 20'sd524287, 1'b0);
    send_point(-20'sd524288, -20'sd524288, 1'b1);
    send_point(20'sd524287, -20'sd524288, 1'b0);
    send_point(-20'sd524288, 20'sd524287, 1'b1);
    send_point(20'sd0, 20'sd0, 1'b0);
    send_point(20'sd1, 20'sd0, 1'b1);
    send_point(-20'sd5, 20'sd9, 1'b0);
    send_point(-20'sd5, 20'sd9, 1'b0);
    send_point(-20'sd5, 20'sd9, 1'b1);
    send_point(20'sd524280, 20'sd524287, 1'b0);
    send_point(20'sd524287, 20'sd524283, 1'b0);
    send_point(20'sd524285, 20'sd524280, 1'b1);
    send_point(-20'sd524288, 20'sd3, 1'b0);
    send_point(-20'sd524283, -20'sd2, 1'b1);

    random_sets(18);
    idle_in_pct  = 54;
    idle_out_pct = 8;
    random_sets(18);
    idle_in_pct  = 0;
    idle_out_pct = 0;
    send_set(MAX_POINTS + 2, 1);
    random_sets(8);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d points in %0d sets, checked %0d normalized results,",
             items_sent, sb.sets_done, sb.results_seen);
    $display("including degenerate, saturating and overfull sets; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
